// ===== hw/rtl/mlr_pkg.sv =====
`default_nettype none

package mlr_pkg;

    localparam int COLOR_WIDTH = 24;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    typedef enum logic [1:0] {
        OCT_SHALLOW_UP = 2'd0,
        OCT_SHALLOW_DN = 2'd1,
        OCT_STEEP_UP   = 2'd2,
        OCT_STEEP_DN   = 2'd3
    } octant_t;

    typedef struct packed {
        logic emit;
        logic last;
    } mlr_flags_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mlr_walker.sv =====
`default_nettype none

module mlr_walker
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          item_valid,
    input  wire logic                          fire,
    input  wire logic                          mode,
    input  wire logic signed [COORD_WIDTH-1:0] start_x,
    input  wire logic signed [COORD_WIDTH-1:0] start_y,
    input  wire logic signed [COORD_WIDTH-1:0] end_x,
    input  wire logic signed [COORD_WIDTH-1:0] end_y,
    output mlr_flags_t                         flags,
    output logic signed [COORD_WIDTH-1:0]      pixel_x,
    output logic signed [COORD_WIDTH-1:0]      pixel_y
);

    localparam int W  = COORD_WIDTH;
    localparam int DW = COORD_WIDTH + 4;
    localparam int SW = COORD_WIDTH + 2;

    logic                 active_reg, active_next;
    logic signed [W-1:0]  walk_x_reg, walk_x_next;
    logic signed [W-1:0]  walk_y_reg, walk_y_next;
    logic signed [W-1:0]  target_x_reg, target_x_next;
    logic signed [W-1:0]  target_y_reg, target_y_next;
    logic signed [DW-1:0] decision_reg, decision_next;
    logic signed [SW-1:0] step_a_reg, step_a_next;
    logic signed [SW-1:0] step_b_reg, step_b_next;
    octant_t              octant_reg, octant_next;

    // load path
    logic                 swap;
    logic signed [W-1:0]  ax, ay, bx, by;
    logic signed [W:0]    dx, dy, abs_dy;
    logic signed [DW-1:0] dx_e, dy_e;
    logic                 shallow, rising;

    // step path
    logic                 more;
    logic signed [DW-1:0] a_e, b_e;

    assign swap = start_x > end_x;
    assign ax   = swap ? end_x : start_x;
    assign ay   = swap ? end_y : start_y;
    assign bx   = swap ? start_x : end_x;
    assign by   = swap ? start_y : end_y;

    assign dx      = $signed({bx[W-1], bx}) - $signed({ax[W-1], ax});
    assign dy      = $signed({by[W-1], by}) - $signed({ay[W-1], ay});
    assign abs_dy  = dy[W] ? -dy : dy;
    assign shallow = dx >= abs_dy;
    assign rising  = !dy[W] && (dy != '0);
    assign dx_e    = {{3{dx[W]}}, dx};
    assign dy_e    = {{3{dy[W]}}, dy};

    assign a_e = {{2{step_a_reg[SW-1]}}, step_a_reg};
    assign b_e = {{2{step_b_reg[SW-1]}}, step_b_reg};

    always_comb
    begin
        case (octant_reg)
            OCT_SHALLOW_UP, OCT_SHALLOW_DN: more = walk_x_reg < target_x_reg;
            OCT_STEEP_UP:                   more = walk_y_reg < target_y_reg;
            default:                        more = walk_y_reg > target_y_reg;
        endcase
    end

    assign flags.emit = item_valid && (mode == MODE_STEP) && active_reg;
    assign flags.last = !more;
    assign pixel_x    = more ? walk_x_reg : target_x_reg;
    assign pixel_y    = more ? walk_y_reg : target_y_reg;

    always_comb
    begin
        active_next   = active_reg;
        walk_x_next   = walk_x_reg;
        walk_y_next   = walk_y_reg;
        target_x_next = target_x_reg;
        target_y_next = target_y_reg;
        decision_next = decision_reg;
        step_a_next   = step_a_reg;
        step_b_next   = step_b_reg;
        octant_next   = octant_reg;

        if (fire && (mode == MODE_LOAD))
        begin
            active_next   = 1'b1;
            walk_x_next   = ax;
            walk_y_next   = ay;
            target_x_next = bx;
            target_y_next = by;
            step_a_next   = {dy, 1'b0};
            step_b_next   = -$signed({dx, 1'b0});
            if (shallow)
            begin
                if (rising)
                begin
                    octant_next   = OCT_SHALLOW_UP;
                    decision_next = {dy_e[DW-2:0], 1'b0} - dx_e;
                end
                else
                begin
                    octant_next   = OCT_SHALLOW_DN;
                    decision_next = {dy_e[DW-2:0], 1'b0} + dx_e;
                end
            end
            else
            begin
                if (rising)
                begin
                    octant_next   = OCT_STEEP_UP;
                    decision_next = dy_e - {dx_e[DW-2:0], 1'b0};
                end
                else
                begin
                    octant_next   = OCT_STEEP_DN;
                    decision_next = dy_e + {dx_e[DW-2:0], 1'b0};
                end
            end
        end
        else if (fire && flags.emit)
        begin
            if (!more)
            begin
                active_next = 1'b0;
            end
            else
            begin
                case (octant_reg)
                    OCT_SHALLOW_UP:
                    begin
                        walk_x_next = walk_x_reg + 1'b1;
                        if (decision_reg > 0)
                        begin
                            walk_y_next   = walk_y_reg + 1'b1;
                            decision_next = decision_reg + a_e + b_e;
                        end
                        else
                        begin
                            decision_next = decision_reg + a_e;
                        end
                    end
                    OCT_SHALLOW_DN:
                    begin
                        walk_x_next = walk_x_reg + 1'b1;
                        if (decision_reg < 0)
                        begin
                            walk_y_next   = walk_y_reg - 1'b1;
                            decision_next = decision_reg + a_e - b_e;
                        end
                        else
                        begin
                            decision_next = decision_reg + a_e;
                        end
                    end
                    OCT_STEEP_UP:
                    begin
                        walk_y_next = walk_y_reg + 1'b1;
                        if (decision_reg < 0)
                        begin
                            walk_x_next   = walk_x_reg + 1'b1;
                            decision_next = decision_reg + a_e + b_e;
                        end
                        else
                        begin
                            decision_next = decision_reg + b_e;
                        end
                    end
                    default:
                    begin
                        walk_y_next = walk_y_reg - 1'b1;
                        if (decision_reg > 0)
                        begin
                            walk_x_next   = walk_x_reg + 1'b1;
                            decision_next = decision_reg + a_e - b_e;
                        end
                        else
                        begin
                            decision_next = decision_reg - b_e;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            walk_x_reg   <= '0;
            walk_y_reg   <= '0;
            target_x_reg <= '0;
            target_y_reg <= '0;
            decision_reg <= '0;
            step_a_reg   <= '0;
            step_b_reg   <= '0;
            octant_reg   <= OCT_SHALLOW_UP;
        end
        else
        begin
            active_reg   <= active_next;
            walk_x_reg   <= walk_x_next;
            walk_y_reg   <= walk_y_next;
            target_x_reg <= target_x_next;
            target_y_reg <= target_y_next;
            decision_reg <= decision_next;
            step_a_reg   <= step_a_next;
            step_b_reg   <= step_b_next;
            octant_reg   <= octant_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/midpoint_line_rasterizer.sv =====
// Midpoint line rasterizer.
// Slave stream: tuser[0] = 0 loads a line from the two endpoints in tdata,
// tuser[0] = 1 asks for the next pixel of the active line. Loads and steps
// without an active line produce no master beat; a load replaces any line
// in progress.
// Master stream: one beat per step, tdata = {color, y, x}, tlast marks the
// exact end point, after which the line is inactive.
// cfg_wr_en/cfg_wr_data write the 24-bit RGB line color, applied to every
// pixel stepped after the write.
// Path: a step beat passes through the input register, then the result
// register, on its way to the master side.
// Throughput: one beat per clock while the master side takes results; each
// step is a compare and an add of the step terms on the line registers.
// Stall: the result register holds while m_tready is low; the input
// register still takes beats until it holds a step of an active line, then
// s_tready drops until the result is taken. Loads never wait on the master side.
// Reset: rst_n clears the line (inactive), color to 0, both streams empty.
`default_nettype none

module midpoint_line_rasterizer
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_wr_en,
    input  wire logic [COLOR_WIDTH-1:0] cfg_wr_data,
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    // start_x, start_y, end_x, end_y
    input  wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // mode
    input  wire logic [0:0]             s_tuser,
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    // pixel_x, pixel_y, pixel_color
    output logic [((2*COORD_WIDTH+COLOR_WIDTH+7)/8)*8-1:0] m_tdata,
    // last_pixel
    output logic                        m_tlast
);

    localparam int W      = COORD_WIDTH;
    localparam int OUT_DW = ((2*COORD_WIDTH+COLOR_WIDTH+7)/8)*8;

    logic                   in_valid_reg;
    logic                   in_mode_reg;
    logic [4*W-1:0]         in_data_reg;
    logic                   out_valid_reg;
    logic signed [W-1:0]    out_x_reg, out_y_reg;
    logic [COLOR_WIDTH-1:0] out_color_reg;
    logic                   out_last_reg;
    logic [COLOR_WIDTH-1:0] color_reg;

    mlr_flags_t             flags;
    logic signed [W-1:0]    pix_x, pix_y;
    logic                   out_free, advance, emit_fire;

    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && (!flags.emit || out_free);
    assign emit_fire = advance && flags.emit;
    assign s_tready  = !in_valid_reg || advance;

    mlr_walker #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_walker (
        .clk       (clk),
        .rst_n     (rst_n),
        .item_valid(in_valid_reg),
        .fire      (advance),
        .mode      (in_mode_reg),
        .start_x   (in_data_reg[W-1:0]),
        .start_y   (in_data_reg[2*W-1:W]),
        .end_x     (in_data_reg[3*W-1:2*W]),
        .end_y     (in_data_reg[4*W-1:3*W]),
        .flags     (flags),
        .pixel_x   (pix_x),
        .pixel_y   (pix_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            color_reg     <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= emit_fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_mode_reg <= s_tuser[0];
            in_data_reg <= s_tdata[4*W-1:0];
        end
        if (emit_fire)
        begin
            out_x_reg     <= pix_x;
            out_y_reg     <= pix_y;
            out_color_reg <= color_reg;
            out_last_reg  <= flags.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_DW'({out_color_reg, out_y_reg, out_x_reg});
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/mlr_checker.sv =====
`default_nettype none

module mlr_checker
    import mlr_pkg::*;
#(
    parameter int COORD_WIDTH = 12
)
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   cfg_wr_en,
    input wire logic [COLOR_WIDTH-1:0] cfg_wr_data,
    input wire logic                   s_tvalid,
    input wire logic                   s_tready,
    input wire logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    input wire logic [0:0]             s_tuser,
    input wire logic                   m_tvalid,
    input wire logic                   m_tready,
    input wire logic [((2*COORD_WIDTH+COLOR_WIDTH+7)/8)*8-1:0] m_tdata,
    input wire logic                   m_tlast
);

    // stalled result beat holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("mlr: stalled master beat changed");

    // input side only backs up behind a stalled output
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
    else $error("mlr: s_tready low without master stall");

    // a new result comes from an earlier accepted step beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && (s_tuser[0] == MODE_STEP), 2))
    else $error("mlr: master beat without matching step beat");

    assert property (@(posedge clk)
        !rst_n |=> !m_tvalid)
    else $error("mlr: master valid during reset");

endmodule

bind midpoint_line_rasterizer mlr_checker #(
    .COORD_WIDTH(COORD_WIDTH)
) u_mlr_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
);

`default_nettype wire
